>>> src/cste_pkg.sv
// shared constants, status codes and saturating helpers for the call stack profiler
`default_nettype none

package cste_pkg;

    localparam int NUM_FUNCS   = 256;
    localparam int STACK_DEPTH = 64;

    localparam int FUNC_W  = 8;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 2;
    localparam int FUNC_AW = $clog2(NUM_FUNCS);
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int ENTRY_W = FUNC_W + 2 * TIME_W;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_END   = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // ticks from resume point to t plus extra, zero when negative
    function automatic logic [TIME_W-1:0] charge(input logic [TIME_W-1:0] t,
                                                 input logic [TIME_W-1:0] resume,
                                                 input logic              extra);
        logic [TIME_W:0] hi;
        logic [TIME_W:0] d;
        hi = {1'b0, t} + {{TIME_W{1'b0}}, extra};
        d  = hi - {1'b0, resume};
        if (hi <= {1'b0, resume}) begin
            return '0;
        end
        return d[TIME_W] ? TIME_MAX : d[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/cste_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module cste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/call_stack_exclusive_time_top.sv
// call stack exclusive time profiler top level
//
// input channel s_*: one beat per parsed event; s_tuser is the kind (0 start,
// 1 end), s_tdata carries func_id and timepoint.
// output channel m_*: at most one beat per event; m_tuser is the status
// (0 normal end, 1 end on empty stack, 2 push onto full stack), m_tdata carries
// done_func, segment_time and total_time.
// the top of the stack lives in registers; the entries below it sit in a
// stack ram, the per-function totals in a totals ram with a valid bit per
// function that reads as zero until first written.
// a start event charges the caller, then spills it to the stack ram; an end
// event reads the new top and total, pops, then updates the total, holding
// while the output register is full; an error event goes to the output
// register. s_tready is high only when the previous event is finished.
// a result sits in the output register while the next event is accepted;
// the block only holds off when a new result finds that register still full.
// reset empties the stack and marks all totals as zero; no
// clearing pass is needed.
`default_nettype none

module call_stack_exclusive_time_top
    import cste_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // func_id[7:0], timepoint[39:8]
    input  wire logic                 s_tuser,   // kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // done_func, segment_time, total_time
    output logic      [STAT_W-1:0]    m_tuser    // status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TOT,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic                   kind_reg, kind_next;
    logic [FUNC_W-1:0]      fid_reg, fid_next;
    logic [TIME_W-1:0]      t_reg, t_next;
    logic [TIME_W-1:0]      rinc_reg, rinc_next;
    logic [TIME_W-1:0]      charge_reg, charge_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [FUNC_W-1:0]      top_func_reg, top_func_next;
    logic [TIME_W-1:0]      top_resume_reg, top_resume_next;
    logic [TIME_W-1:0]      top_accum_reg, top_accum_next;
    logic [TIME_W-1:0]      seg_reg, seg_next;
    logic [FUNC_W-1:0]      done_reg, done_next;
    logic                   hit_reg, hit_next;
    logic                   rng_reg, rng_next;
    logic [STAT_W-1:0]      res_stat_reg, res_stat_next;
    logic [NUM_FUNCS-1:0]   tot_valid_reg, tot_valid_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [STAT_W-1:0]      m_tuser_reg, m_tuser_next;

    logic                   stk_we, stk_re;
    logic [STK_AW-1:0]      stk_waddr, stk_raddr;
    logic [ENTRY_W-1:0]     stk_wdata, stk_rdata;
    logic                   tot_we, tot_re;
    logic [FUNC_AW-1:0]     tot_waddr, tot_raddr;
    logic [TIME_W-1:0]      tot_wdata, tot_rdata;

    logic                   in_kind;
    logic [FUNC_W-1:0]      in_fid;
    logic [TIME_W-1:0]      in_t;
    logic                   accept;
    logic                   out_free;
    logic [CNT_W-1:0]       cnt_m1, cnt_m2;
    logic [FUNC_AW-1:0]     top_addr;
    logic [TIME_W-1:0]      total_val;

    cste_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    cste_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_FUNCS)
    ) u_totals_ram (
        .aclk  (aclk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (tot_re),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    assign in_kind  = s_tuser;
    assign in_fid   = s_tdata[FUNC_W-1:0];
    assign in_t     = s_tdata[FUNC_W +: TIME_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign top_addr = FUNC_AW'(top_func_reg);

    assign total_val = rng_reg ? sat_add(hit_reg ? tot_rdata : '0, seg_reg) : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        fid_next        = fid_reg;
        t_next          = t_reg;
        rinc_next       = rinc_reg;
        charge_next     = charge_reg;
        count_next      = count_reg;
        top_func_next   = top_func_reg;
        top_resume_next = top_resume_reg;
        top_accum_next  = top_accum_reg;
        seg_next        = seg_reg;
        done_next       = done_reg;
        hit_next        = hit_reg;
        rng_next        = rng_reg;
        res_stat_next   = res_stat_reg;
        tot_valid_next  = tot_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        stk_we    = 1'b0;
        stk_waddr = cnt_m1[STK_AW-1:0];
        stk_wdata = {sat_add(top_accum_reg, charge_reg), top_resume_reg, top_func_reg};
        stk_re    = 1'b0;
        stk_raddr = cnt_m2[STK_AW-1:0];
        tot_we    = 1'b0;
        tot_waddr = FUNC_AW'(done_reg);
        tot_wdata = total_val;
        tot_re    = 1'b0;
        tot_raddr = top_addr;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = in_kind;
                    fid_next    = in_fid;
                    t_next      = in_t;
                    rinc_next   = (in_t == TIME_MAX) ? TIME_MAX : in_t + TIME_W'(1);
                    charge_next = charge(in_t, top_resume_reg, in_kind);
                    rng_next    = (32'(top_func_reg) < NUM_FUNCS);
                    hit_next    = tot_valid_reg[top_addr];
                    if (in_kind == KIND_START) begin
                        if (count_reg == CNT_W'(STACK_DEPTH)) begin
                            res_stat_next = STAT_OVERFLOW;
                            state_next    = ST_EMIT;
                        end else begin
                            state_next = ST_EXEC;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            res_stat_next = STAT_EMPTY;
                            state_next    = ST_EMIT;
                        end else begin
                            stk_re     = (count_reg > CNT_W'(1));
                            tot_re     = 1'b1;
                            state_next = ST_EXEC;
                        end
                    end
                end
            end
            ST_EXEC: begin
                if (kind_reg == KIND_START) begin
                    stk_we          = (count_reg != '0);
                    top_func_next   = fid_reg;
                    top_resume_next = t_reg;
                    top_accum_next  = '0;
                    count_next      = count_reg + CNT_W'(1);
                    state_next      = ST_IDLE;
                end else begin
                    seg_next   = sat_add(top_accum_reg, charge_reg);
                    done_next  = top_func_reg;
                    count_next = cnt_m1;
                    if (count_reg > CNT_W'(1)) begin
                        top_func_next   = stk_rdata[FUNC_W-1:0];
                        top_resume_next = rinc_reg;
                        top_accum_next  = stk_rdata[FUNC_W+TIME_W +: TIME_W];
                    end
                    state_next = ST_TOT;
                end
            end
            ST_TOT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {total_val, seg_reg, done_reg};
                    m_tuser_next  = STAT_OK;
                    if (rng_reg) begin
                        tot_we = 1'b1;
                        tot_valid_next[FUNC_AW'(done_reg)] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tuser_next  = res_stat_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        fid_reg        <= fid_next;
        t_reg          <= t_next;
        rinc_reg       <= rinc_next;
        charge_reg     <= charge_next;
        top_func_reg   <= top_func_next;
        top_resume_reg <= top_resume_next;
        top_accum_reg  <= top_accum_next;
        seg_reg        <= seg_next;
        done_reg       <= done_next;
        hit_reg        <= hit_next;
        rng_reg        <= rng_next;
        res_stat_reg   <= res_stat_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            tot_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tot_valid_reg <= tot_valid_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire
